// File: hdl/lurl_pkg.sv
// Shared widths, limits and types for the longest unique run length block.
package lurl_pkg;

    localparam int CODE_W   = 8;
    localparam int ALPHABET = 256;
    localparam int POS_W    = 16;
    localparam int POSC_W   = 17;
    localparam int LEN_W    = 9;

    localparam logic [POSC_W-1:0] MAX_LEN = 17'h10000;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [POSC_W-1:0] posc_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef struct packed {
        logic  set;
        logic  clear;
        code_t code;
    } seen_upd_t;

endpackage

// File: hdl/lurl_ram.sv
// Generic simple dual-port RAM with one registered read port.
module lurl_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/lurl_seen.sv
// Per-code seen flags, set on use and cleared together at the end of a string.
module lurl_seen import lurl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  seen_upd_t upd,
    input  code_t     rd_code,
    output logic      rd_seen
);

    logic [ALPHABET-1:0] seen_reg;
    logic [ALPHABET-1:0] seen_next;

    always_comb begin
        seen_next = seen_reg;
        if (upd.clear) begin
            seen_next = '0;
        end else if (upd.set) begin
            seen_next[upd.code] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else begin
            seen_reg <= seen_next;
        end
    end

    assign rd_seen = seen_reg[rd_code];

endmodule

// File: hdl/longest_unique_run_length.sv
// Top level: sliding-window longest unique run over a byte stream.
//
//  Channel  | Direction | tdata                    | tlast          | tuser
//  s_       | in        | char_code[7:0]           | end_of_string  | -
//  m_       | out       | best_length[8:0], 0 pad  | is_final       | too_long
//
// One byte per cycle while the output is not stalled; each result passes the stage and output registers.
// A new byte's last-position read and the byte under work's write-back share a cycle; equal codes are forwarded.
// Reset clears all counters and seen flags; table contents need no clearing.
// A stalled output holds the result and the byte under work; new bytes wait.
module longest_unique_run_length import lurl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [8:0] best_length, [15:9] zero
    output logic        m_tlast,
    output logic        m_tuser    // [0] too_long
);

    logic      s_acc;
    logic      st_go;
    logic      st_valid_reg, st_valid_next;
    code_t     st_code_reg;
    logic      st_last_reg;
    logic      fwd_hit_reg;
    pos_t      fwd_pos_reg;

    posc_t     pos_reg, pos_next;
    pos_t      ws_reg, ws_next;
    len_t      best_reg, best_next;
    logic      ovf_reg, ovf_next;

    logic      m_valid_reg, m_valid_next;
    len_t      m_len_reg;
    logic      m_last_reg;
    logic      m_long_reg;

    logic      full;
    logic      seen;
    pos_t      rd_pos;
    pos_t      prev_pos;
    pos_t      ws_cand;
    posc_t     run;
    logic      wr_en;
    seen_upd_t upd;

    assign st_go    = st_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || st_go;
    assign s_acc    = s_tvalid && s_tready;

    assign full  = (pos_reg == MAX_LEN);
    assign wr_en = st_go && !full;

    lurl_ram #(
        .DEPTH (ALPHABET),
        .WIDTH (POS_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (st_code_reg),
        .wdata (pos_reg[POS_W-1:0]),
        .re    (s_acc),
        .raddr (s_tdata[CODE_W-1:0]),
        .rdata (rd_pos)
    );

    always_comb begin
        upd.set   = wr_en;
        upd.clear = st_go && st_last_reg;
        upd.code  = st_code_reg;
    end

    lurl_seen u_seen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .rd_code (st_code_reg),
        .rd_seen (seen)
    );

    always_comb begin
        prev_pos  = fwd_hit_reg ? fwd_pos_reg : rd_pos;
        ws_cand   = (seen && prev_pos >= ws_reg) ? prev_pos + 16'd1 : ws_reg;
        run       = {1'b0, pos_reg[POS_W-1:0]} - {1'b0, ws_cand} + 17'd1;
        pos_next  = pos_reg;
        ws_next   = ws_reg;
        best_next = best_reg;
        ovf_next  = ovf_reg;
        if (st_go) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                ws_next  = ws_cand;
                pos_next = pos_reg + 17'd1;
                if (run[LEN_W-1:0] > best_reg) begin
                    best_next = run[LEN_W-1:0];
                end
            end
        end
    end

    always_comb begin
        st_valid_next = st_valid_reg;
        if (s_acc) begin
            st_valid_next = 1'b1;
        end else if (st_go) begin
            st_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (st_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pos_reg      <= '0;
            ws_reg       <= '0;
            best_reg     <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
            if (st_go && st_last_reg) begin
                pos_reg  <= '0;
                ws_reg   <= '0;
                best_reg <= '0;
                ovf_reg  <= 1'b0;
            end else begin
                pos_reg  <= pos_next;
                ws_reg   <= ws_next;
                best_reg <= best_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st_code_reg <= s_tdata[CODE_W-1:0];
            st_last_reg <= s_tlast;
            fwd_hit_reg <= wr_en && (st_code_reg == s_tdata[CODE_W-1:0]);
            fwd_pos_reg <= pos_reg[POS_W-1:0];
        end
        if (st_go) begin
            m_len_reg  <= best_next;
            m_last_reg <= st_last_reg;
            m_long_reg <= ovf_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_len_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_long_reg;

    a_best_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_len_reg != '0))
        else $error("result length is zero");

    a_window_order : assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, ws_reg} <= pos_reg) && (pos_reg <= MAX_LEN))
        else $error("window start beyond position or position beyond limit");

    a_best_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        best_reg <= len_t'(ALPHABET))
        else $error("best length exceeds alphabet size");

    a_ovf_full : assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> full)
        else $error("overflow flag set below position limit");

endmodule
